>>> hw/rtl/chacha_pkg.sv
// Shared types, constants and helper functions of the ChaCha20 byte-stream cipher.
package chacha_pkg;

  localparam int STATE_WORDS       = 16;
  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_01    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_01  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_START = 3'd6;

  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  typedef logic [STATE_WORDS-1:0][31:0] blk_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      ctr_start;
  } cipher_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       new_block;
    logic       msg_start;
    logic       last_in_block;
    logic [5:0] pos;
  } item_t;

  typedef struct packed {
    logic pop;
    logic calc;
    logic blk_ok;
  } bk_stat_t;

  function automatic blk_t make_init(input cipher_cfg_t cfg, input logic [31:0] ctr);
    blk_t w;
    w[3:0]  = SIGMA;
    w[11:4] = cfg.key;
    w[12]   = ctr;
    w[15:13] = cfg.nonce;
    return w;
  endfunction

  function automatic logic [31:0] rot_step(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/chacha20_stream_cipher_core.sv
// ChaCha20 byte-stream cipher core: configuration registers, front, queue and back.
// Each accepted byte is XORed with the next keystream byte and returned with its
// end-of-message flag. Bytes pass at one per cycle while the current 64-byte block
// lasts and the output accepts them. The first byte of each block waits for the
// block function, a single shared unit of four quarter-round lanes doing one
// add-xor-rotate step per cycle through DOUBLE_ROUNDS double rounds, then a
// final add of the input block and a handoff. A queue of QUEUE_DEPTH bytes takes
// the following bytes meanwhile; once it is full the input stalls until the block is ready.
// The message counter restarts at counter_start after each end-of-message byte.
module chacha20_stream_cipher_core import chacha_pkg::*; #(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_result_byte,
  output logic                  out_end_of_message_out,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cipher_cfg_t cfg_r;
  logic        push, q_full, q_valid, q_pop;
  item_t       push_item, q_head;
  bk_stat_t    bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_KEY_01:    cfg_r.key[1:0]   <= cfg_data;
        REG_KEY_23:    cfg_r.key[3:2]   <= cfg_data;
        REG_KEY_45:    cfg_r.key[5:4]   <= cfg_data;
        REG_KEY_67:    cfg_r.key[7:6]   <= cfg_data;
        REG_NONCE_01:  cfg_r.nonce[1:0] <= cfg_data;
        REG_NONCE_2:   cfg_r.nonce[2]   <= cfg_data[31:0];
        REG_CTR_START: cfg_r.ctr_start  <= cfg_data[31:0];
        default:       cfg_r            <= cfg_r;
      endcase
    end
  end

  chacha_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_message(in_end_of_message),
    .q_full           (q_full),
    .push             (push),
    .push_item        (push_item)
  );

  chacha_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  chacha_back #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_valid),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_result_byte       (out_result_byte),
    .out_end_of_message_out(out_end_of_message_out),
    .stat                  (bk_stat)
  );

  a_block_before_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.new_block |-> bk_stat.blk_ok && !bk_stat.calc)
    else $error("byte popped before its keystream block was ready");

  a_calc_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bk_stat.calc) |-> $past(q_valid) && $past(q_head.new_block))
    else $error("block function started without a byte waiting for it");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |=> out_valid)
    else $error("popped transaction did not reach the output register");

endmodule

>>> hw/rtl/chacha_queue.sv
// Small in-order queue of classified items between the front and back parts.
module chacha_queue import chacha_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/chacha_front.sv
// Front part: accepts input transactions and tags each byte with its block position.
module chacha_front import chacha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic [5:0] pos_r;
  logic       active_r;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.data          = in_data_byte;
    push_item.eom           = in_end_of_message;
    push_item.new_block     = (pos_r == '0);
    push_item.msg_start     = !active_r;
    push_item.last_in_block = (pos_r == 6'd63);
    push_item.pos           = pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
    end else if (push) begin
      if (in_end_of_message) begin
        pos_r    <= '0;
        active_r <= 1'b0;
      end else begin
        pos_r    <= pos_r + 1'b1;
        active_r <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/chacha_core.sv
// Block function: four quarter-round lanes, one add-xor-rotate step per cycle.
module chacha_core import chacha_pkg::*; #(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] counter,
  input  cipher_cfg_t cfg,
  input  logic [3:0]  idx,
  output logic [31:0] ks_word,
  output logic        busy,
  output logic        done
);

  localparam int RW = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

  core_state_t   state_r;
  logic [RW-1:0] rnd_r;
  logic          diag_r;
  logic [1:0]    step_r;
  logic          done_r;
  logic [31:0]   ctr_r;
  blk_t          work_r, work_nxt, init_blk;

  assign busy    = (state_r != C_IDLE);
  assign done    = done_r;
  assign ks_word = work_r[idx];
  assign init_blk = make_init(cfg, ctr_r);

  always_comb begin
    logic [1:0]  ob, oc, od;
    logic [3:0]  ia, ib, ic, id, ix, iy, iz;
    logic [31:0] sum, mix;
    work_nxt = work_r;
    for (int l = 0; l < 4; l++) begin
      ob = l[1:0] + (diag_r ? 2'd1 : 2'd0);
      oc = l[1:0] + (diag_r ? 2'd2 : 2'd0);
      od = l[1:0] + (diag_r ? 2'd3 : 2'd0);
      ia = {2'b00, l[1:0]};
      ib = {2'b01, ob};
      ic = {2'b10, oc};
      id = {2'b11, od};
      if (!step_r[0]) begin
        ix = ia;
        iy = ib;
        iz = id;
      end else begin
        ix = ic;
        iy = id;
        iz = ib;
      end
      sum = work_r[ix] + work_r[iy];
      mix = work_r[iz] ^ sum;
      work_nxt[ix] = sum;
      work_nxt[iz] = rot_step(mix, step_r);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          work_r <= make_init(cfg, counter);
          ctr_r  <= counter;
        end
      end
      C_ROUND: begin
        work_r <= work_nxt;
      end
      C_ADD: begin
        for (int i = 0; i < STATE_WORDS; i++) begin
          work_r[i] <= work_r[i] + init_blk[i];
        end
      end
      default: begin
        work_r <= work_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      diag_r  <= 1'b0;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            state_r <= C_ROUND;
            rnd_r   <= '0;
            diag_r  <= 1'b0;
            step_r  <= '0;
          end
        end
        C_ROUND: begin
          step_r <= step_r + 1'b1;
          if (step_r == 2'd3) begin
            diag_r <= !diag_r;
            if (diag_r) begin
              rnd_r <= rnd_r + 1'b1;
              if (rnd_r == RW'(DOUBLE_ROUNDS - 1)) begin
                state_r <= C_ADD;
              end
            end
          end
        end
        C_ADD: begin
          state_r <= C_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/chacha_back.sv
// Back part: runs the block function when needed and XORs bytes into the output register.
module chacha_back import chacha_pkg::*; #(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cipher_cfg_t cfg,
  input  logic        q_valid,
  input  item_t       q_head,
  output logic        q_pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_result_byte,
  output logic        out_end_of_message_out,
  output bk_stat_t    stat
);

  logic        calc_r, have_r, out_valid_r;
  logic [31:0] blk_cnt_r, ctr_use;
  logic [7:0]  out_data_r;
  logic        out_eom_r;
  logic        core_start, core_busy, core_done;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign ctr_use    = q_head.msg_start ? cfg.ctr_start : blk_cnt_r;
  assign core_start = q_valid && q_head.new_block && !have_r && !calc_r && !core_busy;
  assign q_pop      = q_valid && (!q_head.new_block || have_r) && (!out_valid_r || out_ready);
  assign ks_byte    = ks_word[8*q_head.pos[1:0] +: 8];

  chacha_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .counter(ctr_use),
    .cfg    (cfg),
    .idx    (q_head.pos[5:2]),
    .ks_word(ks_word),
    .busy   (core_busy),
    .done   (core_done)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_head.data ^ ks_byte;
      out_eom_r  <= q_head.eom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      blk_cnt_r   <= '0;
    end else begin
      if (core_start) begin
        calc_r    <= 1'b1;
        blk_cnt_r <= ctr_use;
      end
      if (core_done) begin
        calc_r <= 1'b0;
        have_r <= 1'b1;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
        if (q_head.new_block) begin
          have_r <= 1'b0;
        end
        if (q_head.last_in_block) begin
          blk_cnt_r <= blk_cnt_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_byte        = out_data_r;
  assign out_end_of_message_out = out_eom_r;

  always_comb begin
    stat.pop    = q_pop;
    stat.calc   = calc_r;
    stat.blk_ok = have_r;
  end

endmodule
